FILE: hw/rtl/kem_pkg.sv
// Shared types and constants for the Kirsch edge magnitude unit.
// No dependencies; every other file in hw/rtl but kem_ram uses this package.
package kem_pkg;

    localparam int PIX_W      = 8;
    localparam int MAG_W      = 12;
    localparam int COORD_W    = 10;
    localparam int RING_N     = 8;
    localparam int SUM_W      = 10;   // three pixels
    localparam int TOTAL_W    = 11;   // eight pixels
    localparam int PROD_W     = 13;   // 8*S and 3*T
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int MIN_SIZE     = 3;

    localparam logic [PIX_W-1:0] PIX_MAX = '1;

    // Ring neighbors clockwise from top-left: TL, T, TR, R, BR, B, BL, L.
    typedef logic [RING_N-1:0][PIX_W-1:0] t_ring;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_center;

endpackage

FILE: hw/rtl/kem_pix_if.sv
// Pixel input channel: valid/ready handshake plus one pixel word.
// Depends on kem_pkg for field widths.
interface kem_pix_if;
    logic                       valid;
    logic                       ready;
    logic [kem_pkg::PIX_W-1:0]  pixel_value;
    logic                       frame_start;

    modport source (output valid, pixel_value, frame_start, input ready);
    modport sink   (input valid, pixel_value, frame_start, output ready);
endinterface

FILE: hw/rtl/kem_edge_if.sv
// Edge result channel: valid/ready handshake plus one result word.
// Depends on kem_pkg for field widths.
interface kem_edge_if;
    logic                         valid;
    logic                         ready;
    logic [kem_pkg::MAG_W-1:0]    edge_magnitude;
    logic [kem_pkg::PIX_W-1:0]    edge_pixel;
    logic [kem_pkg::COORD_W-1:0]  center_row;
    logic [kem_pkg::COORD_W-1:0]  center_col;

    modport source (output valid, edge_magnitude, edge_pixel, center_row, center_col,
                     input ready);
    modport sink   (input valid, edge_magnitude, edge_pixel, center_row, center_col,
                    output ready);
endinterface

FILE: hw/rtl/kirsch_edge_magnitude_unit.sv
// Kirsch edge magnitude unit. Takes one 8-bit grey pixel per clock in raster order and,
// for every interior pixel, returns the largest |5S - 3T| over the eight compass
// rotations (floor 1), an 8-bit saturated copy and the center row/column. Border
// pixels give no result. Throughput is one pixel per clock; the only stall is a full
// output register whose word the consumer has not taken. A word is accepted at the
// edge that the pipe advances; its result passes stage 1 and then the kem_kirsch pipe.
// The two previous rows sit in one MAX_WIDTH-deep RAM (upper and middle lines side by
// side), read at the current column on acceptance and rewritten there when the word
// leaves stage 1; a read of that column in the same clock (frame_start at column 0
// twice) is forwarded. Line-store contents are undefined until written, so after reset
// no clearing pass is needed. Width and height are clamped to [3, MAX_WIDTH] and [3,
// MAX_HEIGHT] on write and may only change while the unit is idle.
module kirsch_edge_magnitude_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kem_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kem_pkg::CFG_DATA_W-1:0] i_cfg_data,
    kem_pix_if.sink                       i_pix,
    kem_edge_if.source                    o_edge
);
    import kem_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int SWW = $clog2(MAX_WIDTH + 1);
    localparam int SWH = $clog2(MAX_HEIGHT + 1);
    localparam int LW  = 2 * PIX_W;

    function automatic int clamp_size(input int v, input int hi);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    // Effective (clamped) frame size
    logic [SWW-1:0] r_w_eff;
    logic [SWH-1:0] r_h_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_eff <= SWW'(clamp_size(WIDTH_RESET, MAX_WIDTH));
            r_h_eff <= SWH'(clamp_size(HEIGHT_RESET, MAX_HEIGHT));
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH: begin
                    r_w_eff <= SWW'(clamp_size(int'(i_cfg_data), MAX_WIDTH));
                end
                REG_IMAGE_HEIGHT: begin
                    r_h_eff <= SWH'(clamp_size(int'(i_cfg_data), MAX_HEIGHT));
                end
                default: begin
                end
            endcase
        end
    end

    // Pipe advance: everything moves unless the output word is stuck.
    logic k_valid;
    logic pipe_en;
    logic accept;

    assign pipe_en     = !k_valid || o_edge.ready;
    assign i_pix.ready = pipe_en;
    assign accept      = i_pix.valid && pipe_en;

    // Stage 0: raster position of the incoming word; frame_start clears it first.
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] col_cur;
    logic [RW-1:0] row_cur;
    logic          emit0;
    logic          col_wrap;
    logic          row_wrap;

    always_comb begin
        col_cur  = i_pix.frame_start ? '0 : r_col;
        row_cur  = i_pix.frame_start ? '0 : r_row;
        emit0    = (32'(row_cur) >= 32'd2) && (32'(col_cur) >= 32'd2)
                && (32'(row_cur) < 32'(r_h_eff)) && (32'(col_cur) < 32'(r_w_eff));
        col_wrap = (32'(col_cur) + 32'd1) >= 32'(r_w_eff);
        row_wrap = (32'(row_cur) + 32'd1) >= 32'(r_h_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (col_wrap) begin
                r_col <= '0;
                r_row <= row_wrap ? '0 : row_cur + RW'(1);
            end else begin
                r_col <= col_cur + CW'(1);
                r_row <= row_cur;
            end
        end
    end

    // Stage 1 registers
    logic             r_s1_valid;
    logic             r_s1_emit;
    logic [PIX_W-1:0] r_s1_pix;
    logic [CW-1:0]    r_s1_col;
    logic [RW-1:0]    r_s1_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (pipe_en) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_emit <= emit0;
            r_s1_pix  <= i_pix.pixel_value;
            r_s1_col  <= col_cur;
            r_s1_row  <= row_cur;
        end
    end

    // Line store: {upper, middle} per column.
    logic          ram_we;
    logic [LW-1:0] ram_wdata;
    logic [LW-1:0] ram_rdata;
    logic          r_fwd_hit;
    logic [LW-1:0] r_fwd_data;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;

    always_comb begin
        {top, mid} = r_fwd_hit ? r_fwd_data : ram_rdata;
    end

    assign ram_we    = pipe_en && r_s1_valid;
    assign ram_wdata = {mid, r_s1_pix};

    kem_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_col),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (col_cur),
        .o_rdata (ram_rdata)
    );

    // Forward the word written in the same clock as a read of that column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (accept) begin
            r_fwd_hit <= ram_we && (r_s1_col == col_cur);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fwd_data <= ram_wdata;
        end
    end

    // Window: 0..2 column c-2 top/mid/bottom, 3..5 column c-1.
    logic [PIX_W-1:0] r_win [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (ram_we) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top;
            r_win[4] <= mid;
            r_win[5] <= r_s1_pix;
        end
    end

    t_ring   ring;
    t_center center;

    always_comb begin
        ring[0]    = r_win[0];
        ring[1]    = r_win[3];
        ring[2]    = top;
        ring[3]    = mid;
        ring[4]    = r_s1_pix;
        ring[5]    = r_win[5];
        ring[6]    = r_win[2];
        ring[7]    = r_win[1];
        center.row = COORD_W'(r_s1_row - RW'(1));
        center.col = COORD_W'(r_s1_col - CW'(1));
    end

    t_center k_center;

    kem_kirsch u_kirsch (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (pipe_en),
        .i_valid     (r_s1_valid && r_s1_emit),
        .i_ring      (ring),
        .i_center    (center),
        .o_valid     (k_valid),
        .o_magnitude (o_edge.edge_magnitude),
        .o_pixel     (o_edge.edge_pixel),
        .o_center    (k_center)
    );

    assign o_edge.valid      = k_valid;
    assign o_edge.center_row = k_center.row;
    assign o_edge.center_col = k_center.col;

endmodule

FILE: hw/rtl/kem_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read-before-write on a same-address collision. No dependencies.
module kem_ram #(
    parameter  int WIDTH  = 16,
    parameter  int DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/kem_kirsch.sv
// Pipelined Kirsch compass operator: ring sums, |5S - 3T| per rotation, max tree.
// Depends on kem_pkg; the final stage is the block's output register.
module kem_kirsch (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  kem_pkg::t_ring            i_ring,
    input  kem_pkg::t_center          i_center,
    output logic                      o_valid,
    output logic [kem_pkg::MAG_W-1:0] o_magnitude,
    output logic [kem_pkg::PIX_W-1:0] o_pixel,
    output kem_pkg::t_center          o_center
);
    import kem_pkg::*;

    // stage A: captured ring
    logic        r_va;
    t_ring       r_ring;
    t_center     r_ctr_a;
    // stage B: triple sums and total
    logic        r_vb;
    logic [SUM_W-1:0]   r_sum [RING_N];
    logic [TOTAL_W-1:0] r_total;
    t_center     r_ctr_b;
    // stage C: absolute differences
    logic        r_vc;
    logic [MAG_W-1:0] r_diff [RING_N];
    t_center     r_ctr_c;
    // output stage
    logic             r_vo;
    logic [MAG_W-1:0] r_mag;
    logic [PIX_W-1:0] r_pix;
    t_center          r_ctr_o;

    logic [SUM_W-1:0]   n_sum [RING_N];
    logic [TOTAL_W-1:0] n_total;
    logic [MAG_W-1:0]   n_diff [RING_N];
    logic [MAG_W-1:0]   n_max4 [RING_N/2];
    logic [MAG_W-1:0]   n_max2 [RING_N/4];
    logic [MAG_W-1:0]   n_mag;

    always_comb begin
        n_total = '0;
        for (int i = 0; i < RING_N; i++) begin
            n_sum[i] = SUM_W'(r_ring[i]) + SUM_W'(r_ring[(i + 1) % RING_N])
                     + SUM_W'(r_ring[(i + 2) % RING_N]);
            n_total  = n_total + TOTAL_W'(r_ring[i]);
        end
    end

    // 5S - 3T == 8S - 3*(S+T)
    always_comb begin
        logic [PROD_W-1:0] a;
        logic [PROD_W-1:0] b;
        logic [PROD_W-1:0] d;
        a = '0;
        b = '0;
        d = '0;
        for (int i = 0; i < RING_N; i++) begin
            a = {r_sum[i], 3'b000};
            b = {1'b0, r_total, 1'b0} + PROD_W'(r_total);
            d = (a >= b) ? (a - b) : (b - a);
            n_diff[i] = d[MAG_W-1:0];
        end
    end

    always_comb begin
        for (int i = 0; i < RING_N / 2; i++) begin
            n_max4[i] = (r_diff[2*i] > r_diff[2*i+1]) ? r_diff[2*i] : r_diff[2*i+1];
        end
        for (int i = 0; i < RING_N / 4; i++) begin
            n_max2[i] = (n_max4[2*i] > n_max4[2*i+1]) ? n_max4[2*i] : n_max4[2*i+1];
        end
        n_mag = (n_max2[0] > n_max2[1]) ? n_max2[0] : n_max2[1];
        if (n_mag == '0) begin
            n_mag = MAG_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vo <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ring  <= i_ring;
            r_ctr_a <= i_center;
            r_sum   <= n_sum;
            r_total <= n_total;
            r_ctr_b <= r_ctr_a;
            r_diff  <= n_diff;
            r_ctr_c <= r_ctr_b;
            r_mag   <= n_mag;
            r_pix   <= (n_mag > MAG_W'(PIX_MAX)) ? PIX_MAX : n_mag[PIX_W-1:0];
            r_ctr_o <= r_ctr_c;
        end
    end

    assign o_valid     = r_vo;
    assign o_magnitude = r_mag;
    assign o_pixel     = r_pix;
    assign o_center    = r_ctr_o;

endmodule

FILE: hw/rtl/kem_checker.sv
// Port-level checks for the Kirsch edge magnitude unit, bound to the top level.
// Depends on kem_pkg and kirsch_edge_magnitude_unit.
module kem_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_pix_valid,
    input logic                          i_pix_ready,
    input logic                          i_edge_valid,
    input logic                          i_edge_ready,
    input logic [kem_pkg::MAG_W-1:0]     i_edge_magnitude,
    input logic [kem_pkg::PIX_W-1:0]     i_edge_pixel,
    input logic [kem_pkg::COORD_W-1:0]   i_center_row,
    input logic [kem_pkg::COORD_W-1:0]   i_center_col
);
    import kem_pkg::*;

    // hold a stalled result word
    a_edge_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_edge_valid && !i_edge_ready |=> i_edge_valid)
        else $error("edge word dropped while stalled");

    a_edge_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_edge_valid && !i_edge_ready |=>
            $stable({i_edge_magnitude, i_edge_pixel, i_center_row, i_center_col}))
        else $error("edge word changed while stalled");

    // input only backs up behind an untaken result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix_ready |-> i_edge_valid && !i_edge_ready)
        else $error("pixel input stalled without a pending result");

    a_mag_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_edge_valid |-> i_edge_magnitude != '0)
        else $error("edge magnitude below floor");

    a_pix_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_edge_valid |-> (i_edge_magnitude > MAG_W'(PIX_MAX))
            ? (i_edge_pixel == PIX_MAX)
            : (MAG_W'(i_edge_pixel) == i_edge_magnitude))
        else $error("edge pixel does not match saturated magnitude");

endmodule

bind kirsch_edge_magnitude_unit kem_checker u_kem_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_pix_valid      (i_pix.valid),
    .i_pix_ready      (i_pix.ready),
    .i_edge_valid     (o_edge.valid),
    .i_edge_ready     (o_edge.ready),
    .i_edge_magnitude (o_edge.edge_magnitude),
    .i_edge_pixel     (o_edge.edge_pixel),
    .i_center_row     (o_edge.center_row),
    .i_center_col     (o_edge.center_col)
);

FILE: verif/kirsch_edge_magnitude_unit_test.sv
// Self-checking bench for the Kirsch edge magnitude unit: pixel stream in, edge words out.
// Uses kem_pkg and the kem_pix_if / kem_edge_if channels from hw/rtl; predicts every
// interior result in step with each accepted pixel word and checks the output in order.
module kirsch_edge_magnitude_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kem_pkg::*;

    localparam int          MAX_W         = 1024;
    localparam int          MAX_H         = 1024;
    // Room for the pipe to drain, plus margin; a no-result pixel may still be in flight.
    localparam int          SETTLE_CYCLES = 16;
    localparam int          HOLD_CYCLES   = 80;
    // Well above the slowest legal run (about 850 words, worst gaps and stalls on both sides).
    localparam int unsigned CYCLE_LIMIT   = 200_000;
    localparam int          REPORT_CAP    = 40;

    typedef struct packed {
        logic [MAG_W-1:0]   magnitude;
        logic [PIX_W-1:0]   level;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_edge_word;

    // One row of the opening script: a pixel word, and the edge word it must yield when
    // that can be read straight off the window contents.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             sof;
        logic             typed;
        t_edge_word       word;
    } t_script_row;

    localparam t_edge_word NO_WORD = '0;

    // Width 3, height at its reset value. Rows 0..2 zero, rows 3..5 full scale:
    //   all-zero window            -> floor of 1
    //   bottom three at 255        -> 5*765 = 3825, level saturates
    //   top three at 0, rest 255   -> |0 - 3*1275| = 3825
    //   all-255 window             -> 0, floored to 1
    // then two back-to-back frame starts at column 0.
    localparam t_script_row OPENING_SCRIPT [20] = '{
        '{8'd0,   1'b1, 1'b0, NO_WORD},
        '{8'd0,   1'b0, 1'b0, NO_WORD},
        '{8'd0,   1'b0, 1'b0, NO_WORD},
        '{8'd0,   1'b0, 1'b0, NO_WORD},
        '{8'd0,   1'b0, 1'b0, NO_WORD},
        '{8'd0,   1'b0, 1'b0, NO_WORD},
        '{8'd0,   1'b0, 1'b0, NO_WORD},
        '{8'd0,   1'b0, 1'b0, NO_WORD},
        '{8'd0,   1'b0, 1'b1, '{12'd1, 8'd1, 10'd1, 10'd1}},
        '{8'd255, 1'b0, 1'b0, NO_WORD},
        '{8'd255, 1'b0, 1'b0, NO_WORD},
        '{8'd255, 1'b0, 1'b1, '{12'd3825, 8'd255, 10'd2, 10'd1}},
        '{8'd255, 1'b0, 1'b0, NO_WORD},
        '{8'd255, 1'b0, 1'b0, NO_WORD},
        '{8'd255, 1'b0, 1'b1, '{12'd3825, 8'd255, 10'd3, 10'd1}},
        '{8'd255, 1'b0, 1'b0, NO_WORD},
        '{8'd255, 1'b0, 1'b0, NO_WORD},
        '{8'd255, 1'b0, 1'b1, '{12'd1, 8'd1, 10'd4, 10'd1}},
        '{8'h5A,  1'b1, 1'b0, NO_WORD},
        '{8'hA5,  1'b1, 1'b0, NO_WORD}
    };

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    kem_pix_if  pix_ch ();
    kem_edge_if edge_ch ();

    kirsch_edge_magnitude_unit #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_pix       (pix_ch),
        .o_edge      (edge_ch)
    );

    // Shadow of the block: registers, both line stores, the six window registers and the
    // raster position. Updated once per accepted pixel word.
    logic [CFG_DATA_W-1:0] cfg_width  = CFG_DATA_W'(WIDTH_RESET);
    logic [CFG_DATA_W-1:0] cfg_height = CFG_DATA_W'(HEIGHT_RESET);
    logic [PIX_W-1:0]      upper_line  [MAX_W];
    logic [PIX_W-1:0]      middle_line [MAX_W];
    logic [PIX_W-1:0]      win [6];     // 0..2: column c-2 top/mid/bottom, 3..5: column c-1
    int unsigned           col_pos = 0;
    int unsigned           row_pos = 0;

    t_edge_word  pending_edges [$];

    bit          src_idle_on   = 1'b0;
    bit          sink_idle_on  = 1'b0;
    bit          long_hold_req = 1'b0;
    int unsigned mismatches    = 0;
    int unsigned pixels_sent   = 0;
    int unsigned edges_checked = 0;
    int unsigned cfg_writes    = 0;
    int unsigned cycle_count   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                              input int unsigned hi);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    // Largest |5S - 3T| over the eight rotations, written as |8S - 3*total|, floor 1.
    function automatic int unsigned compass_peak(input t_ring ring);
        int unsigned total, best, s, a, b, d;
        total = 0;
        best  = 1;
        for (int k = 0; k < RING_N; k++) total += 32'(ring[k]);
        for (int k = 0; k < RING_N; k++) begin
            s = 32'(ring[k]) + 32'(ring[(k + 1) % RING_N]) + 32'(ring[(k + 2) % RING_N]);
            a = 8 * s;
            b = 3 * total;
            d = (a >= b) ? a - b : b - a;
            if (d > best) best = d;
        end
        return best;
    endfunction

    // Skewed toward flat and full-scale areas so that both the floor and the
    // saturated magnitudes come up often.
    function automatic logic [PIX_W-1:0] grey_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return PIX_MAX;
            2:       return PIX_W'($urandom_range(0, 3));
            3:       return PIX_W'($urandom_range(252, 255));
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Advance the shadow by one accepted pixel word; queue the edge word it yields, if
    // any. A typed word from the opening script stands in for the predicted one.
    task automatic track_pixel(input logic [PIX_W-1:0] value, input logic sof,
                               input logic typed, input t_edge_word typed_word);
        int unsigned      w_eff, h_eff, slot, peak;
        logic [PIX_W-1:0] top, mid;
        t_ring            ring;
        t_edge_word       word;
        w_eff = clamp_dim(cfg_width, MAX_W);
        h_eff = clamp_dim(cfg_height, MAX_H);
        if (sof) begin
            col_pos = 0;
            row_pos = 0;
        end
        slot = (col_pos < MAX_W) ? col_pos : MAX_W - 1;
        top  = upper_line[slot];
        mid  = middle_line[slot];
        // Only interior centers inside the current size give a word.
        if (row_pos >= 2 && col_pos >= 2 && row_pos < h_eff && col_pos < w_eff) begin
            ring[0] = win[0];
            ring[1] = win[3];
            ring[2] = top;
            ring[3] = mid;
            ring[4] = value;
            ring[5] = win[5];
            ring[6] = win[2];
            ring[7] = win[1];
            peak           = compass_peak(ring);
            word.magnitude = MAG_W'(peak);
            word.level     = (peak > PIX_MAX) ? PIX_MAX : PIX_W'(peak);
            word.row       = COORD_W'(row_pos - 1);
            word.col       = COORD_W'(col_pos - 1);
            pending_edges  = {pending_edges, (typed ? typed_word : word)};
        end
        upper_line[slot]  = mid;
        middle_line[slot] = value;
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top;
        win[4] = mid;
        win[5] = value;
        // Wrap column and row; a counter already past a shrunken size wraps here too.
        if (col_pos + 1 >= w_eff) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h_eff) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endtask

    // Offer one pixel word, optionally after an idle burst, and hold it until taken.
    task automatic push_pixel(input logic [PIX_W-1:0] value, input logic sof,
                              input logic typed, input t_edge_word typed_word);
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel_value <= value;
        pix_ch.frame_start <= sof;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        track_pixel(value, sof, typed, typed_word);
        pixels_sent++;
    endtask

    // Drop valid, drain every predicted word, then give in-flight no-result pixels time
    // to leave the pipe so that the block is idle for the next register write.
    task automatic settle();
        pix_ch.valid <= 1'b0;
        while (pending_edges.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one or both size registers; keep the write enable high across both.
    task automatic configure(input bit set_w, input logic [CFG_DATA_W-1:0] w,
                             input bit set_h, input logic [CFG_DATA_W-1:0] h);
        if (set_w) begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_IMAGE_WIDTH;
            cfg_data  <= w;
            @(posedge i_clk);
            cfg_width = w;
            cfg_writes++;
        end
        if (set_h) begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_IMAGE_HEIGHT;
            cfg_data  <= h;
            @(posedge i_clk);
            cfg_height = h;
            cfg_writes++;
        end
        cfg_we <= 1'b0;
    endtask

    // One setting of the size registers followed by a burst of random pixels. A wider
    // frame always opens with a frame start so that no line-store entry is read before
    // it is written; a narrower or equal one keeps the counters (mid-frame resize).
    // sof_odds gives the one-in-N chance of a stray frame start (0: none).
    task automatic run_phase(input bit set_w, input logic [CFG_DATA_W-1:0] w,
                             input bit set_h, input logic [CFG_DATA_W-1:0] h,
                             input int unsigned n_words, input bit with_hold,
                             input int unsigned sof_odds);
        int unsigned old_w;
        bit          restart;
        logic        sof;
        old_w = clamp_dim(cfg_width, MAX_W);
        configure(set_w, w, set_h, h);
        restart = clamp_dim(cfg_width, MAX_W) > old_w;
        for (int unsigned i = 0; i < n_words; i++) begin
            if (with_hold && i == n_words / 2) long_hold_req = 1'b1;
            sof = (i == 0 && restart) || (sof_odds != 0 && $urandom_range(1, sof_odds) == 1);
            push_pixel(grey_sample(), sof, 1'b0, NO_WORD);
        end
        settle();
    endtask

    task automatic compare_field(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            if (mismatches < REPORT_CAP)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // Result side: ready with random stall bursts, plus one long hold on request so that
    // the output register fills and the block stalls its pixel input.
    initial begin : edge_sink
        edge_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                edge_ch.ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                edge_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                edge_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Check every accepted edge word against the oldest prediction.
    always @(posedge i_clk) begin
        t_edge_word want;
        if (i_rst_n && edge_ch.valid && edge_ch.ready) begin
            if (pending_edges.size() == 0) begin
                if (mismatches < REPORT_CAP)
                    $display("%0t: edge word with nothing predicted, expected none, actual row %0d col %0d",
                             $time, edge_ch.center_row, edge_ch.center_col);
                mismatches++;
            end else begin
                want = pending_edges.pop_front();
                compare_field("edge_magnitude", 16'(want.magnitude), 16'(edge_ch.edge_magnitude));
                compare_field("edge_pixel", 16'(want.level), 16'(edge_ch.edge_pixel));
                compare_field("center_row", 16'(want.row), 16'(edge_ch.center_row));
                compare_field("center_col", 16'(want.col), 16'(edge_ch.center_col));
                edges_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d edge words outstanding",
                     cycle_count, pending_edges.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : main_flow
        int unsigned             random_words, n;
        bit                      set_w, set_h;
        logic [CFG_DATA_W-1:0]   w, h;
        pix_ch.valid       <= 1'b0;
        pix_ch.pixel_value <= '0;
        pix_ch.frame_start <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_IMAGE_WIDTH;
        cfg_data           <= '0;
        for (int k = 0; k < MAX_W; k++) begin
            upper_line[k]  = '0;
            middle_line[k] = '0;
        end
        for (int k = 0; k < 6; k++) win[k] = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;

        // Opening script: narrow frame, height left at its reset value.
        configure(1'b1, CFG_DATA_W'(3), 1'b0, '0);
        for (int i = 0; i < $size(OPENING_SCRIPT); i++)
            push_pixel(OPENING_SCRIPT[i].pixel, OPENING_SCRIPT[i].sof,
                       OPENING_SCRIPT[i].typed, OPENING_SCRIPT[i].word);
        settle();

        // Small frames that wrap rows and frames without a frame start.
        run_phase(1'b1, 11'd5, 1'b1, 11'd4, 60, 1'b0, 150);
        // Shrink mid-row to below the minimum: the column left past the edge wraps.
        run_phase(1'b1, 11'd0, 1'b1, 11'd2, 40, 1'b0, 150);
        run_phase(1'b1, 11'd1, 1'b1, 11'd0, 30, 1'b0, 150);
        // Wider frame with one long output hold in the middle.
        run_phase(1'b1, 11'd16, 1'b1, 11'd6, 150, 1'b1, 150);
        run_phase(1'b1, 11'd12, 1'b1, 11'd1025, 80, 1'b0, 150);
        // Largest sizes, clamped to the maximum: a short wide stretch, then a narrow,
        // tall frame that picks up the counters left there.
        run_phase(1'b1, 11'd2047, 1'b1, 11'd3, 60, 1'b0, 0);
        run_phase(1'b1, 11'd3, 1'b1, 11'd1024, 60, 1'b0, 0);

        // Random settings, mostly small; idling on each side switched per setting.
        random_words = 0;
        while (random_words < 200) begin
            set_w = $urandom_range(0, 2) != 0;
            set_h = !set_w || $urandom_range(0, 1) == 1;
            case ($urandom_range(0, 9))
                0:       w = CFG_DATA_W'($urandom_range(0, 2));
                1:       w = CFG_DATA_W'($urandom_range(1025, 2047));
                default: w = CFG_DATA_W'($urandom_range(3, 20));
            endcase
            case ($urandom_range(0, 9))
                0:       h = CFG_DATA_W'($urandom_range(0, 2));
                1:       h = CFG_DATA_W'($urandom_range(13, 2047));
                default: h = CFG_DATA_W'($urandom_range(3, 12));
            endcase
            n            = $urandom_range(40, 80);
            src_idle_on  = $urandom_range(0, 3) != 0;
            sink_idle_on = $urandom_range(0, 3) != 0;
            run_phase(set_w, w, set_h, h, n, random_words == 0, 150);
            random_words += n;
        end

        // Last stretch at full rate on both sides.
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        run_phase(1'b1, CFG_DATA_W'($urandom_range(3, 20)), 1'b1,
                  CFG_DATA_W'($urandom_range(3, 12)), 100, 1'b0, 150);

        $display("Covered %0d pixel words, %0d edge words checked, %0d register writes.",
                 pixels_sent, edges_checked, cfg_writes);
        $display("Sizes from the clamped minimum to the clamped maximum, mid-frame resizes, long output hold.");
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
